// ===== rtl/core/tetra_point_locator_macros.svh =====
// Assertion helpers for the point locator.
`ifndef TETRA_POINT_LOCATOR_MACROS_SVH
`define TETRA_POINT_LOCATOR_MACROS_SVH

// Same-cycle implication.
`define TPL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TPL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tpl_pkg.sv =====
package tpl_pkg;

   localparam int CNT_W  = 11;   // element counts and scan index
   localparam int ERR_W  = 58;   // unsaturated error sum, worst case FRAC_BITS = 8
   localparam int SQ_W   = 56;   // one squared distance term
   localparam int NCOEF  = 12;   // 9 inverse words, 3 offset words
   localparam int ROW_W  = NCOEF * 32;

   localparam logic [1:0] REQ_LOAD_COEF   = 2'd0;
   localparam logic [1:0] REQ_LOAD_CORNER = 2'd1;
   localparam logic [1:0] REQ_LOCATE      = 2'd2;
   localparam logic [1:0] REQ_READ        = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic CSR_BOUNDARY = 1'b0;
   localparam logic CSR_IN_USE   = 1'b1;

   typedef logic signed [31:0] weight_type;

   // One scored table entry leaving the datapath.
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] idx;
      weight_type [3:0] w;
      logic [ERR_W-1:0] err;
   } tpl_hit_type;

   function automatic weight_type sat32(input logic signed [66:0] x);
      weight_type r;
      if (x > 67'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (x < -67'sd2147483648) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/core/tpl_datapath.sv =====
module tpl_datapath
   import tpl_pkg::*;
#(
   parameter int MAX_ELEMS = 1024,
   parameter int FRAC_BITS = 16,
   localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [3:0]               wr_slot,
   input  logic [31:0]              wr_data,
   input  logic                     rd_en,
   input  logic [CNT_W-1:0]         rd_idx,
   input  weight_type [2:0]         point,
   output tpl_hit_type              hit
);
   localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

   logic [ROW_W-1:0] mem [MAX_ELEMS];

   logic                         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [CNT_W-1:0]             i1_ff, i2_ff, i3_ff, i4_ff, i5_ff, i6_ff, i7_ff;
   logic [ROW_W-1:0]             row_ff;
   logic signed [32:0]           d_ff [3];
   weight_type                   inv_ff [9];
   logic signed [64:0]           pr_ff [9];
   weight_type [3:0]             w4_ff, w5_ff, w6_ff, w7_ff;
   logic [31:0]                  e_ff [4];
   logic [SQ_W-1:0]              sq_ff [4];
   logic [ERR_W-1:0]             err_ff;

   weight_type [3:0]             w4_in;
   weight_type                   w3_in;
   logic [31:0]                  e_in [4];

   // Word-wise write into a full-entry row; reads return the whole row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][32*wr_slot +: 32] <= wr_data;
      end
      if (rd_en) begin
         row_ff <= mem[AW'(rd_idx)];
      end
   end

   always_comb begin
      logic signed [66:0] s;
      for (int r = 0; r < 3; r++) begin
         s = 67'(pr_ff[3*r]) + 67'(pr_ff[3*r+1]) + 67'(pr_ff[3*r+2]);
         w4_in[r] = sat32(s);
      end
      w4_in[3] = '0;
   end

   always_comb begin
      logic signed [66:0] t;
      logic signed [32:0] wx;
      t = 67'(ONE) - (67'(w4_ff[0]) + 67'(w4_ff[1]) + 67'(w4_ff[2]));
      w3_in = sat32(t);
      for (int r = 0; r < 4; r++) begin
         wx = (r == 3) ? 33'(w3_in) : 33'(w4_ff[r]);
         if (wx < 0) e_in[r] = 32'(-wx);
         else if (wx > ONE) e_in[r] = 32'(wx - ONE);
         else e_in[r] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff} <= '0;
      end else begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff} <=
            {rd_en, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff};
      end
   end

   always_ff @(posedge clock) begin
      logic [63:0] pp;
      i1_ff <= rd_idx;
      i2_ff <= i1_ff;
      i3_ff <= i2_ff;
      i4_ff <= i3_ff;
      i5_ff <= i4_ff;
      i6_ff <= i5_ff;
      i7_ff <= i6_ff;
      for (int c = 0; c < 3; c++) begin
         d_ff[c] <= 33'(point[c]) - 33'(signed'(row_ff[32*(9+c) +: 32]));
      end
      for (int k = 0; k < 9; k++) begin
         inv_ff[k] <= row_ff[32*k +: 32];
         pr_ff[k]  <= (65'(inv_ff[k]) * 65'(d_ff[k%3])) >>> FRAC_BITS;
      end
      w4_ff <= w4_in;
      w5_ff <= {w3_in, w4_ff[2:0]};
      for (int r = 0; r < 4; r++) begin
         e_ff[r]  <= e_in[r];
         pp        = 64'(e_ff[r]) * 64'(e_ff[r]);
         sq_ff[r] <= SQ_W'(pp >> FRAC_BITS);
      end
      w6_ff  <= w5_ff;
      w7_ff  <= w6_ff;
      err_ff <= ERR_W'(sq_ff[0]) + ERR_W'(sq_ff[1]) + ERR_W'(sq_ff[2]) + ERR_W'(sq_ff[3]);
   end

   assign hit.valid = v7_ff;
   assign hit.idx   = i7_ff;
   assign hit.w     = w7_ff;
   assign hit.err   = err_ff;

endmodule

// ===== rtl/core/tpl_corner.sv =====
module tpl_corner
   import tpl_pkg::*;
#(
   parameter int MAX_ELEMS = 1024,
   parameter int MAX_VERTS = 1024,
   localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [1:0]               wr_slot,
   input  logic [9:0]               wr_value,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   input  logic [CNT_W-1:0]         boundary,
   output logic signed [10:0]       cons [4]
);
   logic [39:0] mem [MAX_ELEMS];
   logic [39:0] row_ff;
   logic [9:0]  clamp;

   assign clamp = (32'(wr_value) >= MAX_VERTS) ? 10'(MAX_VERTS - 1) : wr_value;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][10*wr_slot +: 10] <= clamp;
      end
      if (rd_en) begin
         row_ff <= mem[rd_addr];
      end
   end

   // vertex index minus boundary count, floored at -1
   always_comb begin
      logic signed [11:0] j;
      for (int k = 0; k < 4; k++) begin
         j = signed'(12'(row_ff[10*k +: 10])) - signed'(12'(boundary));
         cons[k] = (j < -12'sd1) ? -11'sd1 : 11'(j);
      end
   end

endmodule

// ===== rtl/core/tetra_point_locator.sv =====
// Loads and out-of-range or empty-table requests: result in the cycle after accept.
// Read: corner memory read in ST_CORNER, then the result is registered. Locate: the
// coefficient memory delivers one entry per cycle into a 7-stage scoring pipeline
// until every entry in use is issued or an exact fit stops it. One item at a time.
// Reset (synchronous): control cleared, in-use 0, boundary 64; memories not cleared.
module tetra_point_locator
   import tpl_pkg::*;
#(
   parameter int MAX_ELEMS = 1024,
   parameter int MAX_VERTS = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [10:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [9:0]           req_entry,
   input  logic [3:0]           req_slot,
   input  logic signed [31:0]   req_value,
   input  logic signed [31:0]   req_point_x,
   input  logic signed [31:0]   req_point_y,
   input  logic signed [31:0]   req_point_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [9:0]           rsp_found_entry,
   output logic signed [31:0]   rsp_weight_a,
   output logic signed [31:0]   rsp_weight_b,
   output logic signed [31:0]   rsp_weight_c,
   output logic signed [31:0]   rsp_weight_d,
   output logic signed [10:0]   rsp_constraint_a,
   output logic signed [10:0]   rsp_constraint_b,
   output logic signed [10:0]   rsp_constraint_c,
   output logic signed [10:0]   rsp_constraint_d,
   output logic [31:0]          rsp_fit_error
);
   `include "tetra_point_locator_macros.svh"

   localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_CORNER = 2'd2;

   logic [CNT_W-1:0] boundary_ff, in_use_ff, used_n;
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, ret_ff, ret_in, best_idx_ff, best_idx_in;
   logic             stop_ff, stop_in, have_ff, have_in;
   weight_type [3:0] best_w_ff, best_w_in;
   logic [ERR_W-1:0] best_err_ff, best_err_in;
   weight_type [2:0] point_ff, point_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [9:0]       found_ff, found_in;
   weight_type [3:0] rw_ff, rw_in;
   logic signed [10:0] rc_ff [4];
   logic signed [10:0] rc_in [4];
   logic [31:0]      fit_ff, fit_in;

   logic             accept, coef_we, corner_we, scan_rd, crn_rd;
   logic             entry_bad, scan_done;
   logic [AW-1:0]    crn_addr;
   logic signed [10:0] cons [4];
   tpl_hit_type      hit;

   assign used_n = (32'(in_use_ff) > MAX_ELEMS) ? CNT_W'(MAX_ELEMS) : in_use_ff;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign entry_bad = 32'(req_entry) >= MAX_ELEMS;
   assign coef_we = accept && (req_type == REQ_LOAD_COEF) && !entry_bad && (req_slot < 4'd12);
   assign corner_we = accept && (req_type == REQ_LOAD_CORNER) && !entry_bad && (req_slot < 4'd4);
   assign scan_rd = (state_ff == ST_SCAN) && (cnt_ff < used_n) && !stop_ff;
   assign scan_done = (state_ff == ST_SCAN) && (ret_ff == cnt_ff)
                      && ((cnt_ff == used_n) || stop_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= CNT_W'(64);
         in_use_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOUNDARY: boundary_ff <= csr_wdata;
            CSR_IN_USE:   in_use_ff   <= csr_wdata;
            default:      ;
         endcase
      end
   end

   tpl_datapath #(.MAX_ELEMS(MAX_ELEMS), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_we),
      .wr_addr (AW'(req_entry)),
      .wr_slot (req_slot),
      .wr_data (req_value),
      .rd_en   (scan_rd),
      .rd_idx  (cnt_ff),
      .point   (point_ff),
      .hit     (hit)
   );

   tpl_corner #(.MAX_ELEMS(MAX_ELEMS), .MAX_VERTS(MAX_VERTS)) u_corner (
      .clock    (clock),
      .wr_en    (corner_we),
      .wr_addr  (AW'(req_entry)),
      .wr_slot  (req_slot[1:0]),
      .wr_value (req_value[9:0]),
      .rd_en    (crn_rd),
      .rd_addr  (crn_addr),
      .boundary (boundary_ff),
      .cons     (cons)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ret_in       = ret_ff;
      stop_in      = stop_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_w_in    = best_w_ff;
      best_err_in  = best_err_ff;
      point_in     = point_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      found_in     = found_ff;
      rw_in        = rw_ff;
      rc_in        = rc_ff;
      fit_in       = fit_ff;
      crn_rd       = 1'b0;
      crn_addr     = AW'(best_idx_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_OK;
               found_in  = req_entry;
               rw_in     = '0;
               fit_in    = '0;
               for (int k = 0; k < 4; k++) rc_in[k] = '0;
               case (req_type)
                  REQ_LOAD_COEF: begin
                     rsp_valid_in = 1'b1;
                     if (!coef_we) status_in = STATUS_RANGE;
                  end
                  REQ_LOAD_CORNER: begin
                     rsp_valid_in = 1'b1;
                     if (!corner_we) status_in = STATUS_RANGE;
                  end
                  default: begin
                     if (used_n == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_EMPTY;
                        found_in     = '0;
                     end else if (req_type == REQ_READ) begin
                        best_w_in   = '0;
                        best_err_in = '0;
                        best_idx_in = CNT_W'(req_entry);
                        if (CNT_W'(req_entry) >= used_n) begin
                           rsp_valid_in = 1'b1;
                           status_in    = STATUS_RANGE;
                        end else begin
                           crn_rd   = 1'b1;
                           crn_addr = AW'(req_entry);
                           state_in = ST_CORNER;
                        end
                     end else begin
                        cnt_in   = '0;
                        ret_in   = '0;
                        stop_in  = 1'b0;
                        have_in  = 1'b0;
                        point_in = {req_point_z, req_point_y, req_point_x};
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_rd) cnt_in = cnt_ff + 1'b1;
            // entries retire in index order; later ones after an exact fit are dropped
            if (hit.valid) begin
               ret_in = ret_ff + 1'b1;
               if (!stop_ff && (!have_ff || hit.err < best_err_ff)) begin
                  have_in     = 1'b1;
                  best_idx_in = hit.idx;
                  best_w_in   = hit.w;
                  best_err_in = hit.err;
                  if (hit.err == '0) stop_in = 1'b1;
               end
            end
            if (scan_done) begin
               crn_rd   = 1'b1;
               state_in = ST_CORNER;
            end
         end
         ST_CORNER: begin
            rsp_valid_in = 1'b1;
            status_in    = STATUS_OK;
            found_in     = best_idx_ff[9:0];
            rw_in        = best_w_ff;
            rc_in        = cons;
            fit_in       = (best_err_ff > ERR_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                : best_err_ff[31:0];
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         ret_ff       <= '0;
         stop_ff      <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         ret_ff       <= ret_in;
         stop_ff      <= stop_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_w_ff   <= best_w_in;
      best_err_ff <= best_err_in;
      point_ff    <= point_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rw_ff       <= rw_in;
      rc_ff       <= rc_in;
      fit_ff      <= fit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_entry  = found_ff;
   assign rsp_weight_a     = rw_ff[0];
   assign rsp_weight_b     = rw_ff[1];
   assign rsp_weight_c     = rw_ff[2];
   assign rsp_weight_d     = rw_ff[3];
   assign rsp_constraint_a = rc_ff[0];
   assign rsp_constraint_b = rc_ff[1];
   assign rsp_constraint_c = rc_ff[2];
   assign rsp_constraint_d = rc_ff[3];
   assign rsp_fit_error    = fit_ff;

   `TPL_ASSERT_NOW(a_hit_in_scan, hit.valid, state_ff == ST_SCAN, "scored entry outside scan")
   `TPL_ASSERT_NOW(a_retire_le_issue, state_ff == ST_SCAN, ret_ff <= cnt_ff, "retired > issued")
   `TPL_ASSERT_NOW(a_issue_bound, state_ff == ST_SCAN, cnt_ff <= used_n, "scan past table")
   `TPL_ASSERT_NEXT(a_corner_done, state_ff == ST_CORNER, rsp_valid, "corner read gave no item")

endmodule
